FILE: rtl/core/tlba_pkg.sv
// tlba_pkg: shared constants, codes and state type of the two-level bitmap allocator
// depends on nothing; imported by every module under rtl/core
package tlba_pkg;

  localparam int WORD_BITS       = 64;
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int ID_W            = 14;
  localparam int DEF_TOP_WORDS   = 4;
  localparam int DEF_LEAF_WORDS  = 256;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY
  } state_t;

endpackage

FILE: rtl/core/tlba_ffz.sv
// tlba_ffz: lowest-clear-bit finder shared by the top scan and the leaf update
// depends on tlba_pkg
module tlba_ffz (
  input  logic [tlba_pkg::WORD_BITS-1:0] word,
  output logic                           found,
  output logic [tlba_pkg::BIT_W-1:0]     index
);
  import tlba_pkg::*;

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        found = 1'b1;
        index = BIT_W'(b);
      end
    end
  end

endmodule

FILE: rtl/core/tlba_leaf_mem.sv
// tlba_leaf_mem: leaf used-bit memory, one write and one registered read port
// depends on tlba_pkg
module tlba_leaf_mem #(
  parameter int DEPTH = tlba_pkg::DEF_LEAF_WORDS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [tlba_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [tlba_pkg::WORD_BITS-1:0] rdata
);
  import tlba_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/two_level_bitmap_id_allocator_top.sv
// two_level_bitmap_id_allocator_top: sequencer, top full-bits and result register
// depends on tlba_pkg, tlba_ffz, tlba_leaf_mem
//
// Usage: drive operation and release_id with start high while busy is low;
// that edge takes the beat. operation OP_ALLOC hands out the lowest free
// identifier, OP_RELEASE returns release_id to the pool.
// One result beat per request: done is high for exactly one cycle with
// granted_id and pool_full. The receiver cannot stall; the beat is gone
// after that cycle.
// Sequencing: a release goes from ST_IDLE to ST_MODIFY and then to the done
// beat. An allocate scans the top words from the first, one per cycle through
// the shared finder, then does a read-modify-write of one leaf word through
// the read and write ports of the leaf memory.
// With every top word full the pool-full beat follows the scan of the last
// top word and no leaf word is touched.
// busy drops with the done beat, so a new request may be taken in the cycle
// done is shown.
// Reset: top full-bits clear at once; the leaf memory is then cleared one
// word per cycle, every word in turn, with busy high throughout.
module two_level_bitmap_id_allocator_top #(
  parameter int TOP_WORDS  = tlba_pkg::DEF_TOP_WORDS,
  parameter int LEAF_WORDS = tlba_pkg::DEF_LEAF_WORDS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic [tlba_pkg::ID_W-1:0] release_id,
  output logic                      done,
  output logic [tlba_pkg::ID_W-1:0] granted_id,
  output logic                      pool_full
);
  import tlba_pkg::*;

  localparam int TW   = (TOP_WORDS > 1) ? $clog2(TOP_WORDS) : 1;
  localparam int LW   = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
  localparam int RLW  = ID_W - BIT_W;
  localparam int LXA  = (TW + BIT_W > RLW) ? TW + BIT_W : RLW;
  localparam int LXW  = (LXA > LW) ? LXA : LW;

  function automatic logic [WORD_BITS-1:0] top_mask(input logic [TW-1:0] tw);
    int base;
    base = int'(tw) * WORD_BITS;
    for (int b = 0; b < WORD_BITS; b++) begin
      top_mask[b] = (base + b) < LEAF_WORDS;
    end
  endfunction

  state_t               state, state_next;
  logic [WORD_BITS-1:0] top_bits [TOP_WORDS];
  logic [TW-1:0]        t;
  logic [LXW-1:0]       leaf;
  logic [BIT_W-1:0]     bitsel;
  op_t                  op_r;
  logic                 in_range;
  logic [LW-1:0]        clr_addr;

  logic                 mem_we;
  logic [LW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [LW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [WORD_BITS-1:0] ffz_word;
  logic                 ffz_found;
  logic [BIT_W-1:0]     ffz_index;

  logic [WORD_BITS-1:0] scan_word;
  logic [LXW-1:0]       rel_leaf;
  logic [LXW-1:0]       cand_leaf;
  logic [TW-1:0]        top_idx;
  logic                 top_set, top_clr;
  logic                 res_fire, res_full;
  logic [ID_W-1:0]      res_id;
  logic                 leaf_fill, accept;

  tlba_ffz u_ffz (
    .word  (ffz_word),
    .found (ffz_found),
    .index (ffz_index)
  );

  tlba_leaf_mem #(
    .DEPTH (LEAF_WORDS),
    .AW    (LW)
  ) u_leaf_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign scan_word = top_bits[t] | ~top_mask(t);
  assign rel_leaf  = LXW'(release_id[ID_W-1:BIT_W]);
  assign cand_leaf = LXW'({t, ffz_index});
  assign top_idx   = TW'(leaf[LXW-1:BIT_W]);
  assign leaf_fill = &(mem_rdata | (WORD_BITS'(1) << ffz_index));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = leaf[LW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = leaf[LW-1:0];
    ffz_word   = mem_rdata;
    top_set    = 1'b0;
    top_clr    = 1'b0;
    res_fire   = 1'b0;
    res_full   = 1'b0;
    res_id     = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LW'(LEAF_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = rel_leaf[LW-1:0];
        if (start) begin
          state_next = (operation == OP_RELEASE) ? ST_MODIFY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ffz_word  = scan_word;
        mem_raddr = cand_leaf[LW-1:0];
        if (ffz_found) begin
          state_next = ST_MODIFY;
        end else if (t == TW'(TOP_WORDS - 1)) begin
          state_next = ST_IDLE;
          res_fire   = 1'b1;
          res_full   = 1'b1;
        end
      end
      ST_MODIFY: begin
        state_next = ST_IDLE;
        res_fire   = 1'b1;
        if (op_r == OP_RELEASE) begin
          res_id = ID_W'({leaf, bitsel});
          if (in_range) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~(WORD_BITS'(1) << bitsel);
            top_clr   = (&mem_rdata) &&
                        (32'(leaf[LXW-1:BIT_W]) < 32'(TOP_WORDS));
          end
        end else if (ffz_found) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WORD_BITS'(1) << ffz_index);
          top_set   = leaf_fill;
          res_id    = ID_W'({leaf, ffz_index});
        end else begin
          top_set  = 1'b1;
          res_full = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(operation);
      t        <= '0;
      leaf     <= rel_leaf;
      bitsel   <= release_id[BIT_W-1:0];
      in_range <= (operation == OP_ALLOC) ||
                  (32'(rel_leaf) < 32'(LEAF_WORDS));
    end else if (state == ST_SCAN) begin
      if (ffz_found) begin
        leaf <= cand_leaf;
      end else begin
        t <= t + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOP_WORDS; i++) begin
        top_bits[i] <= '0;
      end
    end else if (top_set) begin
      top_bits[top_idx][leaf[BIT_W-1:0]] <= 1'b1;
    end else if (top_clr) begin
      top_bits[top_idx][leaf[BIT_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      granted_id <= res_id;
      pool_full  <= res_full;
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_MODIFY || $past(state) == ST_SCAN))
    else $error("result beat without a finishing step");

  a_full_zero_id: assert property (@(posedge clk) disable iff (rst)
    (done && pool_full) |-> (granted_id == '0))
    else $error("pool full beat carries a nonzero id");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!done && !top_set && !top_clr))
    else $error("activity during clearing pass");

endmodule
